// ===== rtl/core/ipv6_text_address_parser_assert.svh =====
// ----------------------------------------------------------------------------
// IPv6 text address parser assertion macros
// Shared concurrent assertion forms for the parser's checker.
// ----------------------------------------------------------------------------
`ifndef IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH
`define IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPV6P_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ipv6 parser port check failed");

// The consequent must hold in the cycle after the antecedent.
`define IPV6P_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ipv6 parser port check failed");

`endif

// ===== rtl/core/ipv6p_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv6 text address parser package
// Types, character codes and token kinds shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6p_pkg;

    localparam int unsigned GROUPS     = 8;
    localparam int unsigned GROUP_W    = 16;
    localparam int unsigned IDX_W      = $clog2(GROUPS);
    localparam int unsigned CNT_W      = IDX_W + 1;
    localparam int unsigned PREFIX_W   = 8;
    localparam int unsigned ASN_W      = 32;
    localparam int unsigned PRE_LSB    = GROUPS * GROUP_W;
    localparam int unsigned ASN_LSB    = PRE_LSB + PREFIX_W;
    localparam int unsigned OUT_W      = ASN_LSB + ASN_W;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [PREFIX_W-1:0] PREFIX_MAX = 8'd128;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_DIGIT = 3'd1;
    localparam logic [2:0] KIND_HEX   = 3'd2;
    localparam logic [2:0] KIND_COLON = 3'd3;
    localparam logic [2:0] KIND_SLASH = 3'd4;
    localparam logic [2:0] KIND_BLANK = 3'd5;

    localparam logic [1:0] MODE_FRONT  = 2'd0;
    localparam logic [1:0] MODE_BACK   = 2'd1;
    localparam logic [1:0] MODE_PREFIX = 2'd2;
    localparam logic [1:0] MODE_ASN    = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] value;
        logic       last;
    } t_token;

endpackage

`default_nettype wire

// ===== rtl/core/ipv6p_front.sv =====
// ----------------------------------------------------------------------------
// IPv6 parser front stage
// Accepts characters and registers them as classified tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // char_code
    input  wire logic              s_axis_tlast,   // last_char
    output logic                   o_tok_valid,
    input  wire logic              i_tok_ready,
    output ipv6p_pkg::t_token      o_tok
);

    logic              r_valid;
    ipv6p_pkg::t_token r_tok;
    ipv6p_pkg::t_token w_tok;
    logic [7:0]        w_c;

    assign w_c = s_axis_tdata;

    always_comb begin
        w_tok.kind  = ipv6p_pkg::KIND_OTHER;
        w_tok.value = 4'd0;
        w_tok.last  = s_axis_tlast;
        if (w_c >= 8'h30 && w_c <= 8'h39) begin
            w_tok.kind  = ipv6p_pkg::KIND_DIGIT;
            w_tok.value = w_c[3:0];
        end else if ((w_c >= 8'h61 && w_c <= 8'h66) || (w_c >= 8'h41 && w_c <= 8'h46)) begin
            w_tok.kind  = ipv6p_pkg::KIND_HEX;
            w_tok.value = 4'(w_c[3:0] + 4'd9);
        end else if (w_c == ipv6p_pkg::CH_COLON) begin
            w_tok.kind = ipv6p_pkg::KIND_COLON;
        end else if (w_c == ipv6p_pkg::CH_SLASH) begin
            w_tok.kind = ipv6p_pkg::KIND_SLASH;
        end else if (w_c == ipv6p_pkg::CH_SPACE || w_c == ipv6p_pkg::CH_TAB) begin
            w_tok.kind = ipv6p_pkg::KIND_BLANK;
        end
    end

    assign s_axis_tready = !r_valid || i_tok_ready;
    assign o_tok_valid   = r_valid;
    assign o_tok         = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_tok <= w_tok;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ipv6p_fifo.sv =====
// ----------------------------------------------------------------------------
// IPv6 parser token queue
// Short queue that decouples the front stage from the parse stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_valid,
    output logic                   o_wr_ready,
    input  wire ipv6p_pkg::t_token i_wr_tok,
    output logic                   o_rd_valid,
    input  wire logic              i_rd_ready,
    output ipv6p_pkg::t_token      o_rd_tok
);

    localparam int unsigned PTR_W = $clog2(ipv6p_pkg::FIFO_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    ipv6p_pkg::t_token r_mem [ipv6p_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push;
    logic              w_pop;

    assign o_wr_ready = (r_count != CNT_W'(ipv6p_pkg::FIFO_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_tok   = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (w_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (w_pop && !w_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_tok;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ipv6p_back.sv =====
// ----------------------------------------------------------------------------
// IPv6 parser back stage
// Applies one token per cycle (unless output stalls) and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6p_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_tok_valid,
    output logic                               o_tok_ready,
    input  wire ipv6p_pkg::t_token             i_tok,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [ipv6p_pkg::OUT_W-1:0]        m_axis_tdata,
    output logic                               m_axis_tuser
);

    localparam int unsigned GW  = ipv6p_pkg::GROUP_W;
    localparam int unsigned CW  = ipv6p_pkg::CNT_W;
    localparam int unsigned IW  = ipv6p_pkg::IDX_W;
    localparam int unsigned PW  = ipv6p_pkg::PREFIX_W;
    localparam int unsigned AW  = ipv6p_pkg::ASN_W;
    localparam int unsigned PSW = PW + 3;
    localparam int unsigned ASW = AW + 4;

    logic [1:0]     r_mode, n_mode;
    logic [GW-1:0]  r_acc, n_acc;
    logic           r_hd, n_hd;
    logic           r_prev, n_prev;
    logic [GW-1:0]  r_front [ipv6p_pkg::GROUPS];
    logic [GW-1:0]  n_front [ipv6p_pkg::GROUPS];
    logic [GW-1:0]  r_back [ipv6p_pkg::GROUPS];
    logic [GW-1:0]  n_back [ipv6p_pkg::GROUPS];
    logic [CW-1:0]  r_fc, n_fc;
    logic [CW-1:0]  r_bc, n_bc;
    logic [PW-1:0]  r_prefix, n_prefix;
    logic [AW-1:0]  r_asn, n_asn;

    logic                        r_out_valid;
    logic [ipv6p_pkg::OUT_W-1:0] r_out_data;
    logic                        r_out_user;

    logic                        w_hex;
    logic [GW-1:0]               w_acc_upd;
    logic                        w_store;
    logic [PSW-1:0]              w_pre_sum;
    logic [ASW-1:0]              w_asn_sum;
    logic                        w_out_free;
    logic                        w_pop;
    logic [CW-1:0]               w_gap_end;
    logic [CW-1:0]               w_start;
    logic [CW-1:0]               w_off;
    logic [ipv6p_pkg::OUT_W-1:0] w_out_data;

    assign w_hex     = (i_tok.kind == ipv6p_pkg::KIND_DIGIT) ||
                       (i_tok.kind == ipv6p_pkg::KIND_HEX);
    assign w_acc_upd = (!r_mode[1] && w_hex) ? {r_acc[GW-5:0], i_tok.value} : r_acc;
    assign w_pre_sum = (PSW'(r_prefix) << 3) + (PSW'(r_prefix) << 1) + PSW'(i_tok.value);
    assign w_asn_sum = (ASW'(r_asn) << 3) + (ASW'(r_asn) << 1) + ASW'(i_tok.value);

    always_comb begin
        n_mode   = r_mode;
        n_acc    = w_acc_upd;
        n_hd     = r_hd;
        n_prefix = r_prefix;
        n_asn    = r_asn;
        n_fc     = r_fc;
        n_bc     = r_bc;
        n_front  = r_front;
        n_back   = r_back;
        w_store  = 1'b0;
        n_prev   = (i_tok.kind == ipv6p_pkg::KIND_COLON);

        if (!r_mode[1]) begin
            case (i_tok.kind)
                ipv6p_pkg::KIND_SLASH: begin
                    w_store = r_hd;
                    n_acc   = '0;
                    n_hd    = 1'b0;
                    n_mode  = ipv6p_pkg::MODE_PREFIX;
                end
                ipv6p_pkg::KIND_COLON: begin
                    if (r_prev) begin
                        n_mode = ipv6p_pkg::MODE_BACK;
                        n_acc  = '0;
                        n_hd   = 1'b0;
                    end else if (r_mode == ipv6p_pkg::MODE_FRONT && !r_hd && r_fc == '0) begin
                        n_acc = '0;
                    end else begin
                        w_store = 1'b1;
                        n_acc   = '0;
                        n_hd    = 1'b0;
                    end
                end
                ipv6p_pkg::KIND_DIGIT, ipv6p_pkg::KIND_HEX: begin
                    n_hd = 1'b1;
                end
                default: begin
                end
            endcase
            if (i_tok.last && !n_mode[1] && n_hd) begin
                w_store = 1'b1;
            end
        end else if (r_mode == ipv6p_pkg::MODE_PREFIX) begin
            if (i_tok.kind == ipv6p_pkg::KIND_DIGIT) begin
                n_prefix = (w_pre_sum > PSW'(ipv6p_pkg::PREFIX_MAX)) ?
                           ipv6p_pkg::PREFIX_MAX : w_pre_sum[PW-1:0];
                n_hd     = 1'b1;
            end else if (i_tok.kind == ipv6p_pkg::KIND_BLANK && r_hd) begin
                n_mode = ipv6p_pkg::MODE_ASN;
            end
        end else if (i_tok.kind == ipv6p_pkg::KIND_DIGIT) begin
            n_asn = (w_asn_sum[ASW-1:AW] != '0) ? '1 : w_asn_sum[AW-1:0];
        end

        if (w_store) begin
            if (r_mode == ipv6p_pkg::MODE_FRONT) begin
                if (r_fc < CW'(ipv6p_pkg::GROUPS)) begin
                    n_front[r_fc[IW-1:0]] = w_acc_upd;
                    n_fc = CW'(r_fc + 1'b1);
                end
            end else if (r_bc < CW'(ipv6p_pkg::GROUPS)) begin
                n_back[r_bc[IW-1:0]] = w_acc_upd;
                n_bc = CW'(r_bc + 1'b1);
            end
        end
    end

    assign w_gap_end = CW'(ipv6p_pkg::GROUPS) - n_bc;
    assign w_start   = (n_fc > w_gap_end) ? n_fc : w_gap_end;

    always_comb begin
        w_off      = '0;
        w_out_data = '0;
        for (int p = 0; p < ipv6p_pkg::GROUPS; p++) begin
            w_off = CW'(p) - w_start;
            if (CW'(p) < n_fc) begin
                w_out_data[p*GW +: GW] = n_front[p];
            end else if (CW'(p) < w_gap_end) begin
                w_out_data[p*GW +: GW] = '0;
            end else begin
                w_out_data[p*GW +: GW] = n_back[w_off[IW-1:0]];
            end
        end
        w_out_data[ipv6p_pkg::PRE_LSB +: PW] = n_mode[1] ? n_prefix : '0;
        w_out_data[ipv6p_pkg::ASN_LSB +: AW] = n_mode[1] ? n_asn : '0;
    end

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign o_tok_ready   = !i_tok.last || w_out_free;
    assign w_pop         = i_tok_valid && o_tok_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ipv6p_pkg::MODE_FRONT;
            r_acc       <= '0;
            r_hd        <= 1'b0;
            r_prev      <= 1'b0;
            r_fc        <= '0;
            r_bc        <= '0;
            r_prefix    <= '0;
            r_asn       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                if (i_tok.last) begin
                    r_mode   <= ipv6p_pkg::MODE_FRONT;
                    r_acc    <= '0;
                    r_hd     <= 1'b0;
                    r_prev   <= 1'b0;
                    r_fc     <= '0;
                    r_bc     <= '0;
                    r_prefix <= '0;
                    r_asn    <= '0;
                end else begin
                    r_mode   <= n_mode;
                    r_acc    <= n_acc;
                    r_hd     <= n_hd;
                    r_prev   <= n_prev;
                    r_fc     <= n_fc;
                    r_bc     <= n_bc;
                    r_prefix <= n_prefix;
                    r_asn    <= n_asn;
                end
            end
            if (w_pop && i_tok.last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_front <= n_front;
            r_back  <= n_back;
        end
        if (w_pop && i_tok.last) begin
            r_out_data <= w_out_data;
            r_out_user <= n_mode[1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ipv6_text_address_parser.sv =====
// ----------------------------------------------------------------------------
// IPv6 text address parser
// Turns an address string such as "2001:db8::1/48 65000" into eight groups,
// a prefix length and an AS number.
// ----------------------------------------------------------------------------
// The block takes one character per cycle, unless the queue or the result
// register stalls it, with no gaps between strings, and gives one result item
// on the character marked by tlast. The result passes the token register, the
// token queue and the result register on its way to the master side. A
// two-entry token queue between the classifier and the parse stage and a result
// register on the output let each side stall on its own.
`default_nettype none

module ipv6_text_address_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // char_code
    input  wire logic                          s_axis_tlast,   // last_char
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // group0, group1, ..., group7, prefix_len, as_number
    output logic [ipv6p_pkg::OUT_W-1:0]        m_axis_tdata,
    output logic                               m_axis_tuser    // has_prefix
);

    logic              w_fr_valid;
    logic              w_fr_ready;
    ipv6p_pkg::t_token w_fr_tok;
    logic              w_q_valid;
    logic              w_q_ready;
    ipv6p_pkg::t_token w_q_tok;

    ipv6p_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_tok_valid   (w_fr_valid),
        .i_tok_ready   (w_fr_ready),
        .o_tok         (w_fr_tok)
    );

    ipv6p_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fr_valid),
        .o_wr_ready (w_fr_ready),
        .i_wr_tok   (w_fr_tok),
        .o_rd_valid (w_q_valid),
        .i_rd_ready (w_q_ready),
        .o_rd_tok   (w_q_tok)
    );

    ipv6p_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok_valid   (w_q_valid),
        .o_tok_ready   (w_q_ready),
        .i_tok         (w_q_tok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ipv6p_chk.sv =====
// ----------------------------------------------------------------------------
// IPv6 parser port checker
// Watches the result port of the parser and is bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv6_text_address_parser_assert.svh"

module ipv6p_chk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [ipv6p_pkg::OUT_W-1:0]   m_axis_tdata,
    input  wire logic                          m_axis_tuser
);

    logic [ipv6p_pkg::OUT_W:0] w_out;
    logic                      w_out_wait;
    logic                      w_pre_ok;
    logic                      w_tail_ok;

    assign w_out      = {m_axis_tuser, m_axis_tdata};
    assign w_out_wait = m_axis_tvalid && !m_axis_tready;
    assign w_pre_ok   = (m_axis_tdata[ipv6p_pkg::PRE_LSB +: ipv6p_pkg::PREFIX_W] <=
                         ipv6p_pkg::PREFIX_MAX);
    assign w_tail_ok  = m_axis_tuser ||
                        (m_axis_tdata[ipv6p_pkg::OUT_W-1:ipv6p_pkg::PRE_LSB] == '0);

    `IPV6P_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, m_axis_tvalid && $stable(w_out))

    `IPV6P_ASSERT_SAME(a_prefix_range, i_clk, i_rst_n, m_axis_tvalid, w_pre_ok)

    `IPV6P_ASSERT_SAME(a_no_prefix_zero, i_clk, i_rst_n, m_axis_tvalid, w_tail_ok)

endmodule

bind ipv6_text_address_parser ipv6p_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// IPv6 text address parser testbench
// Streams address strings into the parser one character per item and checks
// every parsed result against the sample table's values or a built-in model
// of the parser. A short table of hand-picked strings runs first, then randomly
// built addresses follow, with random gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned GROUPS   = ipv6p_pkg::GROUPS;
    localparam int unsigned GROUP_W  = ipv6p_pkg::GROUP_W;
    localparam int unsigned PREFIX_W = ipv6p_pkg::PREFIX_W;
    localparam int unsigned ASN_W    = ipv6p_pkg::ASN_W;
    localparam int unsigned OUT_W    = ipv6p_pkg::OUT_W;

    localparam int RANDOM_ITEMS = 1550;
    localparam int STALL_LIMIT  = 200;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic                       has_prefix;
        logic [ASN_W-1:0]           as_number;
        logic [PREFIX_W-1:0]        prefix_len;
        logic [GROUPS-1:0][GROUP_W-1:0] groups;
    } t_parsed_addr;

    typedef struct {
        string        text;
        bit           typed;
        t_parsed_addr want;
    } t_sample_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tuser;

    t_parsed_addr        pending_addrs[$];
    t_sample_row         sample_rows[$];
    logic [7:0]          addr_text[$];
    string               hex_chars = "0123456789abcdefABCDEF";
    bit                  quiet;
    int                  mismatches;
    int                  stalled_cycles;

    logic [1:0]          cur_mode;
    logic [GROUP_W-1:0]  group_val;
    bit                  group_digits;
    bit                  after_colon;
    logic [GROUP_W-1:0]  front_vals[GROUPS];
    logic [GROUP_W-1:0]  back_vals[GROUPS];
    int unsigned         front_num;
    int unsigned         back_num;
    logic [PREFIX_W-1:0] prefix_val;
    logic [ASN_W-1:0]    asn_val;

    ipv6_text_address_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        cur_mode     = ipv6p_pkg::MODE_FRONT;
        group_val    = '0;
        group_digits = 1'b0;
        after_colon  = 1'b0;
        front_num    = 0;
        back_num     = 0;
        prefix_val   = '0;
        asn_val      = '0;
        for (int g = 0; g < GROUPS; g++) begin
            front_vals[g] = '0;
            back_vals[g]  = '0;
        end
    endfunction

    function automatic void stash_group();
        if (cur_mode == ipv6p_pkg::MODE_FRONT) begin
            if (front_num < GROUPS) begin
                front_vals[front_num] = group_val;
                front_num++;
            end
        end else if (back_num < GROUPS) begin
            back_vals[back_num] = group_val;
            back_num++;
        end
        group_val    = '0;
        group_digits = 1'b0;
    endfunction

    function automatic bit parse_char(logic [7:0] code, bit last, output t_parsed_addr addr);
        int          hex;
        bit          is_dec;
        bit          is_blank;
        bit          in_head;
        bit          in_tail;
        logic [63:0] wide;
        int unsigned gap_end;
        int unsigned first_back;
        hex      = -1;
        is_dec   = (code >= "0" && code <= "9");
        is_blank = (code == ipv6p_pkg::CH_SPACE || code == ipv6p_pkg::CH_TAB);
        if (is_dec) begin
            hex = code - "0";
        end else if (code >= "a" && code <= "f") begin
            hex = code - "a" + 10;
        end else if (code >= "A" && code <= "F") begin
            hex = code - "A" + 10;
        end
        addr    = '0;
        in_head = (cur_mode == ipv6p_pkg::MODE_FRONT || cur_mode == ipv6p_pkg::MODE_BACK);
        if (in_head) begin
            if (code == ipv6p_pkg::CH_SLASH) begin
                if (group_digits) stash_group();
                group_val    = '0;
                group_digits = 1'b0;
                cur_mode     = ipv6p_pkg::MODE_PREFIX;
            end else if (code == ipv6p_pkg::CH_COLON) begin
                if (after_colon) begin
                    cur_mode     = ipv6p_pkg::MODE_BACK;
                    group_val    = '0;
                    group_digits = 1'b0;
                end else if (cur_mode == ipv6p_pkg::MODE_FRONT && !group_digits &&
                             front_num == 0) begin
                    group_val = '0;
                end else begin
                    stash_group();
                end
            end else if (hex >= 0) begin
                group_val    = {group_val[GROUP_W-5:0], 4'(hex)};
                group_digits = 1'b1;
            end
        end else if (cur_mode == ipv6p_pkg::MODE_PREFIX) begin
            if (is_dec) begin
                wide         = 64'(prefix_val) * 64'd10 + 64'(code - "0");
                prefix_val   = (wide > 64'(ipv6p_pkg::PREFIX_MAX)) ?
                               ipv6p_pkg::PREFIX_MAX : wide[PREFIX_W-1:0];
                group_digits = 1'b1;
            end else if (is_blank && group_digits) begin
                cur_mode = ipv6p_pkg::MODE_ASN;
            end
        end else if (is_dec) begin
            wide    = 64'(asn_val) * 64'd10 + 64'(code - "0");
            asn_val = (wide > 64'hFFFF_FFFF) ? '1 : wide[ASN_W-1:0];
        end
        after_colon = (code == ipv6p_pkg::CH_COLON);

        if (!last) return 1'b0;

        in_head = (cur_mode == ipv6p_pkg::MODE_FRONT || cur_mode == ipv6p_pkg::MODE_BACK);
        if (in_head && group_digits) stash_group();
        gap_end    = GROUPS - back_num;
        first_back = (front_num > gap_end) ? front_num : gap_end;
        for (int p = 0; p < GROUPS; p++) begin
            if (p < front_num) addr.groups[p] = front_vals[p];
            else if (p < gap_end) addr.groups[p] = '0;
            else addr.groups[p] = back_vals[(p - first_back) % GROUPS];
        end
        in_tail         = !in_head;
        addr.prefix_len = in_tail ? prefix_val : '0;
        addr.has_prefix = in_tail;
        addr.as_number  = in_tail ? asn_val : '0;
        clear_parser();
        return 1'b1;
    endfunction

    function automatic t_parsed_addr addr_of(logic [15:0] g0, logic [15:0] g7,
                                             logic [7:0] plen, logic has, logic [31:0] asn);
        t_parsed_addr a;
        a            = '0;
        a.groups[0]  = g0;
        a.groups[7]  = g7;
        a.prefix_len = plen;
        a.has_prefix = has;
        a.as_number  = asn;
        return a;
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(0, 1) ? ipv6p_pkg::CH_SPACE : ipv6p_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 6))
            0: return ipv6p_pkg::CH_COLON;
            1: return ipv6p_pkg::CH_SLASH;
            2: return blank_char();
            3: return 8'("0" + $urandom_range(0, 9));
            4: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int group_count();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
    endfunction

    function automatic void push_group();
        int digits;
        if ($urandom_range(0, 9) == 0) digits = $urandom_range(0, 1) ? 0 : $urandom_range(5, 6);
        else digits = $urandom_range(1, 4);
        repeat (digits) begin
            if ($urandom_range(0, 19) == 0) addr_text.push_back(noise_char());
            addr_text.push_back(hex_chars[$urandom_range(0, 21)]);
        end
    endfunction

    function automatic void build_address();
        int  n_front;
        int  n_back;
        bit  with_gap;
        addr_text.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) addr_text.push_back(noise_char());
            return;
        end
        with_gap = ($urandom_range(0, 3) != 0);
        n_front  = group_count();
        n_back   = with_gap ? group_count() : 0;
        for (int g = 0; g < n_front; g++) begin
            if (g > 0) addr_text.push_back(ipv6p_pkg::CH_COLON);
            push_group();
        end
        if (with_gap) begin
            addr_text.push_back(ipv6p_pkg::CH_COLON);
            addr_text.push_back(ipv6p_pkg::CH_COLON);
        end
        for (int g = 0; g < n_back; g++) begin
            if (g > 0) addr_text.push_back(ipv6p_pkg::CH_COLON);
            push_group();
        end
        if ($urandom_range(0, 1)) begin
            addr_text.push_back(ipv6p_pkg::CH_SLASH);
            if ($urandom_range(0, 4) == 0) addr_text.push_back(ipv6p_pkg::CH_SPACE);
            repeat ($urandom_range(0, 4)) addr_text.push_back(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 2))
                    addr_text.push_back(blank_char());
                repeat ($urandom_range(0, 11))
                    addr_text.push_back(8'("0" + $urandom_range(0, 9)));
            end
        end
        if (addr_text.size() == 0) addr_text.push_back(hex_chars[$urandom_range(0, 21)]);
    endfunction

    task automatic send_char(logic [7:0] code, bit last, bit typed, t_parsed_addr want);
        int           gap;
        t_parsed_addr addr;
        @(negedge i_clk);
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (parse_char(code, last, addr)) pending_addrs.push_back(typed ? want : addr);
    endtask

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %h, got %h", what, want, got);
    endfunction

    task automatic check_addr(t_parsed_addr got);
        t_parsed_addr want;
        if (pending_addrs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result item with nothing pending: %h", got);
            return;
        end
        want = pending_addrs.pop_front();
        for (int g = 0; g < GROUPS; g++)
            if (got.groups[g] != want.groups[g])
                note_mismatch($sformatf("group%0d", g), want.groups[g], got.groups[g]);
        if (got.prefix_len != want.prefix_len)
            note_mismatch("prefix_len", want.prefix_len, got.prefix_len);
        if (got.has_prefix != want.has_prefix)
            note_mismatch("has_prefix", want.has_prefix, got.has_prefix);
        if (got.as_number != want.as_number)
            note_mismatch("as_number", want.as_number, got.as_number);
    endtask

    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            check_addr({m_axis_tuser, m_axis_tdata});
        end
    end

    initial begin
        stalled_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int  len;
        int  sent;
        int  strings;
        bit  paused;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        quiet         = 1'b0;
        mismatches    = 0;
        clear_parser();

        // Double colon alone, byte 0xFF and prefix saturation, hex overflow
        // with both letter cases, and a triple colon with a blank before the prefix.
        sample_rows.push_back('{"::", 1'b1, addr_of(16'h0, 16'h0, 8'd0, 1'b0, 32'd0)});
        sample_rows.push_back('{"\377/9:99\t7", 1'b1,
                                addr_of(16'h0, 16'h0, 8'd128, 1'b1, 32'd7)});
        sample_rows.push_back('{"12345::aF", 1'b1,
                                addr_of(16'h2345, 16'h00af, 8'd0, 1'b0, 32'd0)});
        sample_rows.push_back('{":::/ 1", 1'b1, addr_of(16'h0, 16'h0, 8'd1, 1'b1, 32'd0)});

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (sample_rows[r]) begin
            len = sample_rows[r].text.len();
            for (int i = 0; i < len; i++)
                send_char(sample_rows[r].text[i], i == len - 1, sample_rows[r].typed,
                          sample_rows[r].want);
        end

        sent    = 0;
        strings = 0;
        paused  = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            build_address();
            quiet = (strings % 7 == 3);
            foreach (addr_text[i])
                send_char(addr_text[i], i == addr_text.size() - 1, 1'b0, '0);
            sent += addr_text.size();
            strings++;
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (pending_addrs.size() != 0) @(negedge i_clk);
            end
        end
        quiet = 1'b0;

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_addrs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
